[hdl/klp_pkg.sv]
// Shared types and constants for the key/value line parser.
// Used by the parser's front end, back end and top level; depends on nothing.
`default_nettype none

package klp_pkg;

   localparam int KEY_WIDTH_DEF   = 32;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   // Byte classes produced by the front end.
   typedef enum logic [3:0] {
      CLS_END,
      CLS_NUL,
      CLS_COMMA,
      CLS_BLANK,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_QUOTE,
      CLS_OTHER
   } klp_class_type;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_SIGNED,
      PH_DIGITS,
      PH_SEEK,
      PH_BLANKS,
      PH_VALUE,
      PH_DONE
   } klp_phase_type;

   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_LINE  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_COMMA = 1'b1;

   typedef struct packed {
      klp_class_type cls;
      logic [7:0]    char_byte;
      logic [3:0]    digit;
   } klp_item_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         value_byte;
      logic signed [31:0] key;
      logic               status;
   } klp_rsp_type;

endpackage

`default_nettype wire

[hdl/key_value_line_parser_core.sv]
// Parser for load lines "<key>, <value>": one byte word in, value bytes and a line summary out.
// Top level; depends on klp_pkg, klp_front, klp_fifo and klp_back.
//
// The parser takes one byte word per clock while neither queue is full; the back end updates
// its state once per word, where the key accumulates through a shift-and-add multiply by ten.
// A word is registered in the item queue, handled by the back end when it reaches the head,
// and any result it causes is registered in the result queue before it can be popped. A short
// queue sits between the classifying front end and the back end, and another holds results,
// so the queues absorb stalls on either side until they fill; the back end also waits whenever
// the result queue is full. Each end marker word yields one line result carrying the key and a
// status flag for a missing comma, then the parser is ready for the next line.
`default_nettype none

module key_value_line_parser_core #(
   parameter int KEY_WIDTH   = klp_pkg::KEY_WIDTH_DEF,
   parameter int QUEUE_DEPTH = klp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_is_end,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_kind,
   output logic [7:0]       rsp_value_byte,
   output logic signed [31:0] rsp_key,
   output logic             rsp_status
);

   localparam int ITEM_W = $bits(klp_pkg::klp_item_type);
   localparam int RSP_W  = $bits(klp_pkg::klp_rsp_type);

   klp_pkg::klp_item_type front_item;
   klp_pkg::klp_item_type back_item;
   klp_pkg::klp_rsp_type  back_rsp;
   klp_pkg::klp_rsp_type  head_rsp;
   logic                  front_push;
   logic                  item_full;
   logic                  item_empty;
   logic                  item_pop;
   logic                  rsp_push;
   logic                  rsp_full;
   logic [ITEM_W-1:0]     item_head_bits;
   logic [RSP_W-1:0]      rsp_head_bits;

   klp_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_char_byte (req_char_byte),
      .req_is_end    (req_is_end),
      .queue_full    (item_full),
      .queue_push    (front_push),
      .queue_item    (front_item)
   );

   klp_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_item),
      .full      (item_full),
      .pop       (item_pop),
      .pop_data  (item_head_bits),
      .empty     (item_empty)
   );

   assign back_item = klp_pkg::klp_item_type'(item_head_bits);

   klp_back #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item       (back_item),
      .item_pop   (item_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (back_rsp)
   );

   klp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_bits),
      .empty     (rsp_empty)
   );

   assign head_rsp       = klp_pkg::klp_rsp_type'(rsp_head_bits);
   assign rsp_kind       = head_rsp.kind;
   assign rsp_value_byte = head_rsp.value_byte;
   assign rsp_key        = head_rsp.key;
   assign rsp_status     = head_rsp.status;

endmodule

`default_nettype wire

[hdl/klp_fifo.sv]
// Small first-in first-out queue built from flip-flops.
// Generic; used between the front and back ends and on the result side.
`default_nettype none

module klp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/klp_front.sv]
// Front end of the parser: takes words from the input channel and classifies each byte.
// Depends on klp_pkg; feeds the queue in front of the back end.
`default_nettype none

module klp_front (
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [7:0]    req_char_byte,
   input  wire logic          req_is_end,
   input  wire logic          queue_full,
   output logic               queue_push,
   output klp_pkg::klp_item_type queue_item
);

   klp_pkg::klp_class_type cls;

   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;

   always_comb begin
      priority if (req_is_end) begin
         cls = klp_pkg::CLS_END;
      end else if (req_char_byte == klp_pkg::CH_NUL) begin
         cls = klp_pkg::CLS_NUL;
      end else if (req_char_byte == klp_pkg::CH_COMMA) begin
         cls = klp_pkg::CLS_COMMA;
      end else if (req_char_byte == klp_pkg::CH_SPACE || req_char_byte == klp_pkg::CH_TAB) begin
         cls = klp_pkg::CLS_BLANK;
      end else if (req_char_byte > klp_pkg::CH_TAB && req_char_byte <= klp_pkg::CH_CR) begin
         // Newline, vertical tab, form feed and carriage return count as whitespace.
         cls = klp_pkg::CLS_SPACE;
      end else if (req_char_byte == klp_pkg::CH_PLUS) begin
         cls = klp_pkg::CLS_PLUS;
      end else if (req_char_byte == klp_pkg::CH_MINUS) begin
         cls = klp_pkg::CLS_MINUS;
      end else if (req_char_byte >= klp_pkg::CH_ZERO && req_char_byte <= klp_pkg::CH_NINE) begin
         cls = klp_pkg::CLS_DIGIT;
      end else if (req_char_byte == klp_pkg::CH_SQUOTE || req_char_byte == klp_pkg::CH_DQUOTE) begin
         cls = klp_pkg::CLS_QUOTE;
      end else begin
         cls = klp_pkg::CLS_OTHER;
      end
   end

   always_comb begin
      queue_item.cls       = cls;
      queue_item.char_byte = req_char_byte;
      queue_item.digit     = 4'(req_char_byte - klp_pkg::CH_ZERO);
   end

endmodule

`default_nettype wire

[hdl/klp_back.sv]
// Back end of the parser: runs the line state machine on classified bytes.
// Depends on klp_pkg; reads the front queue and writes the result queue.
`default_nettype none

module klp_back #(
   parameter int KEY_WIDTH = klp_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_empty,
   input  wire klp_pkg::klp_item_type item,
   output logic                      item_pop,
   input  wire logic                 rsp_full,
   output logic                      rsp_push,
   output klp_pkg::klp_rsp_type      rsp_data
);

   klp_pkg::klp_phase_type phase_ff, phase_in;
   logic [KEY_WIDTH-1:0]   key_accum_ff, key_accum_in;
   logic                   key_negative_ff, key_negative_in;
   logic [7:0]             delimiter_ff, delimiter_in;
   logic                   string_ended_ff, string_ended_in;

   logic                   fire;
   logic                   is_end;
   logic                   live;
   logic                   in_key_part;
   logic [KEY_WIDTH-1:0]   key_times_ten;
   logic [KEY_WIDTH-1:0]   key_final;
   logic [KEY_WIDTH+31:0]  key_extended;

   assign fire   = !item_empty && !rsp_full;
   assign item_pop = fire;
   assign is_end = (item.cls == klp_pkg::CLS_END);
   assign live   = fire && !is_end && !string_ended_ff && (item.cls != klp_pkg::CLS_NUL);
   assign in_key_part = (phase_ff == klp_pkg::PH_SKIP) || (phase_ff == klp_pkg::PH_SIGNED) ||
                        (phase_ff == klp_pkg::PH_DIGITS) || (phase_ff == klp_pkg::PH_SEEK);

   assign key_times_ten = (key_accum_ff << 3) + (key_accum_ff << 1) + KEY_WIDTH'(item.digit);
   assign key_final     = key_negative_ff ? ('0 - key_accum_ff) : key_accum_ff;
   assign key_extended  = {{32{key_final[KEY_WIDTH-1]}}, key_final};

   // Next state.
   always_comb begin
      phase_in        = phase_ff;
      key_accum_in    = key_accum_ff;
      key_negative_in = key_negative_ff;
      delimiter_in    = delimiter_ff;
      string_ended_in = string_ended_ff;
      if (fire && is_end) begin
         phase_in        = klp_pkg::PH_SKIP;
         key_accum_in    = '0;
         key_negative_in = 1'b0;
         delimiter_in    = klp_pkg::CH_NEWLINE;
         string_ended_in = 1'b0;
      end else if (fire && !string_ended_ff && item.cls == klp_pkg::CLS_NUL) begin
         string_ended_in = 1'b1;
      end else if (live) begin
         if (in_key_part && item.cls == klp_pkg::CLS_COMMA) begin
            phase_in = klp_pkg::PH_BLANKS;
         end else begin
            unique case (phase_ff)
               klp_pkg::PH_SKIP: begin
                  if (item.cls == klp_pkg::CLS_PLUS || item.cls == klp_pkg::CLS_MINUS) begin
                     key_negative_in = (item.cls == klp_pkg::CLS_MINUS);
                     phase_in        = klp_pkg::PH_SIGNED;
                  end else if (item.cls == klp_pkg::CLS_DIGIT) begin
                     key_accum_in = KEY_WIDTH'(item.digit);
                     phase_in     = klp_pkg::PH_DIGITS;
                  end else if (item.cls != klp_pkg::CLS_BLANK &&
                               item.cls != klp_pkg::CLS_SPACE) begin
                     phase_in = klp_pkg::PH_SEEK;
                  end
               end
               klp_pkg::PH_SIGNED, klp_pkg::PH_DIGITS: begin
                  if (item.cls == klp_pkg::CLS_DIGIT) begin
                     key_accum_in = key_times_ten;
                     phase_in     = klp_pkg::PH_DIGITS;
                  end else begin
                     phase_in = klp_pkg::PH_SEEK;
                  end
               end
               klp_pkg::PH_BLANKS: begin
                  if (item.cls == klp_pkg::CLS_QUOTE) begin
                     delimiter_in = item.char_byte;
                     phase_in     = klp_pkg::PH_VALUE;
                  end else if (item.cls != klp_pkg::CLS_BLANK) begin
                     // An unquoted value runs to the next newline.
                     delimiter_in = klp_pkg::CH_NEWLINE;
                     phase_in = (item.char_byte == klp_pkg::CH_NEWLINE) ?
                                klp_pkg::PH_DONE : klp_pkg::PH_VALUE;
                  end
               end
               klp_pkg::PH_VALUE: begin
                  if (item.char_byte == delimiter_ff) begin
                     phase_in = klp_pkg::PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Outputs.
   always_comb begin
      rsp_push = 1'b0;
      rsp_data = '0;
      if (fire && is_end) begin
         rsp_push        = 1'b1;
         rsp_data.kind   = klp_pkg::KIND_LINE;
         rsp_data.key    = key_extended[31:0];
         rsp_data.status = in_key_part ? klp_pkg::STATUS_NO_COMMA : klp_pkg::STATUS_OK;
      end else if (live) begin
         if ((phase_ff == klp_pkg::PH_BLANKS && item.cls != klp_pkg::CLS_BLANK &&
              item.cls != klp_pkg::CLS_QUOTE && item.char_byte != klp_pkg::CH_NEWLINE) ||
             (phase_ff == klp_pkg::PH_VALUE && item.char_byte != delimiter_ff)) begin
            rsp_push            = 1'b1;
            rsp_data.kind       = klp_pkg::KIND_VALUE;
            rsp_data.value_byte = item.char_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= klp_pkg::PH_SKIP;
         key_accum_ff    <= '0;
         key_negative_ff <= 1'b0;
         delimiter_ff    <= klp_pkg::CH_NEWLINE;
         string_ended_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         key_accum_ff    <= key_accum_in;
         key_negative_ff <= key_negative_in;
         delimiter_ff    <= delimiter_in;
         string_ended_ff <= string_ended_in;
      end
   end

   a_end_clears_line: assert property (@(posedge clock) disable iff (reset)
      (fire && is_end) |=> (phase_ff == klp_pkg::PH_SKIP && !string_ended_ff &&
                            key_accum_ff == '0))
      else $error("line state not cleared after end marker");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (!rsp_full && fire))
      else $error("result written without room or without an item");

   a_value_stays_in_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.kind == klp_pkg::KIND_VALUE) |=> (phase_ff == klp_pkg::PH_VALUE))
      else $error("value byte emitted outside the value phase");

   a_ended_holds: assert property (@(posedge clock) disable iff (reset)
      (string_ended_ff && !(fire && is_end)) |=> string_ended_ff)
      else $error("end of text flag dropped before the end marker");

   a_ended_silent: assert property (@(posedge clock) disable iff (reset)
      (string_ended_ff && !is_end) |-> !rsp_push)
      else $error("output produced after end of text");

endmodule

`default_nettype wire

[sim/klp_line_checker.sv]
// Scoreboard for the key/value line parser: watches the byte and result queues,
// predicts every result from the accepted words and compares them in order.
// Depends on klp_pkg for the phase enum, character codes and the result layout.

module klp_line_checker
   import klp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [7:0]         req_char_byte,
   input  logic               req_is_end,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic               rsp_kind,
   input  logic [7:0]         rsp_value_byte,
   input  logic signed [31:0] rsp_key,
   input  logic               rsp_status,
   output int                 error_count,
   output int                 pending
);

   // Parser state as the predictor tracks it.
   klp_phase_type line_phase;
   logic [31:0]   key_accum;
   logic          key_negative;
   logic [7:0]    value_delim;
   logic          text_ended;

   klp_rsp_type   expected_words[$];
   klp_rsp_type   predicted;
   klp_rsp_type   oldest;

   initial begin
      error_count = 0;
      pending     = 0;
   end

   function automatic void clear_line();
      line_phase   = PH_SKIP;
      key_accum    = '0;
      key_negative = 1'b0;
      value_delim  = CH_NEWLINE;
      text_ended   = 1'b0;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // Advances the line state by one word; returns 1 when the word yields a result.
   function automatic bit parse_word(input logic [7:0] c, input logic last,
                                     output klp_rsp_type r);
      logic [31:0] magnitude;
      bit          in_value;
      r        = '0;
      in_value = 1'b0;
      if (last) begin
         magnitude = key_negative ? -key_accum : key_accum;
         r.kind    = KIND_LINE;
         r.key     = magnitude;
         r.status  = (line_phase < PH_BLANKS) ? STATUS_NO_COMMA : STATUS_OK;
         clear_line();
         return 1'b1;
      end
      if (text_ended) return 1'b0;
      if (c == CH_NUL) begin
         text_ended = 1'b1;
         return 1'b0;
      end
      // The first comma ends the key part whatever state the key is in.
      if (line_phase <= PH_SEEK && c == CH_COMMA) begin
         line_phase = PH_BLANKS;
         return 1'b0;
      end
      case (line_phase)
         PH_SKIP: begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               key_negative = (c == CH_MINUS);
               line_phase   = PH_SIGNED;
            end else if (is_digit(c)) begin
               key_accum  = 32'(c - CH_ZERO);
               line_phase = PH_DIGITS;
            end else begin
               line_phase = PH_SEEK;
            end
         end
         PH_SIGNED, PH_DIGITS: begin
            if (is_digit(c)) begin
               key_accum  = key_accum * 32'd10 + 32'(c - CH_ZERO);
               line_phase = PH_DIGITS;
            end else begin
               line_phase = PH_SEEK;
            end
         end
         PH_BLANKS: begin
            if (c == CH_SPACE || c == CH_TAB) begin
            end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
               value_delim = c;
               line_phase  = PH_VALUE;
            end else begin
               value_delim = CH_NEWLINE;
               line_phase  = PH_VALUE;
               in_value    = 1'b1;
            end
         end
         PH_VALUE: in_value = 1'b1;
         default: ;
      endcase
      if (!in_value) return 1'b0;
      if (c == value_delim) begin
         line_phase = PH_DONE;
         return 1'b0;
      end
      r.kind       = KIND_VALUE;
      r.value_byte = c;
      return 1'b1;
   endfunction

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         expected_words.delete();
      end else begin
         if (req_push && !req_full) begin
            if (parse_word(req_char_byte, req_is_end, predicted))
               expected_words.push_back(predicted);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               note_failure($sformatf("unexpected result: kind %0d byte %02h key %0d status %0d",
                  rsp_kind, rsp_value_byte, rsp_key, rsp_status));
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_kind !== oldest.kind || rsp_value_byte !== oldest.value_byte ||
                   rsp_key !== oldest.key || rsp_status !== oldest.status)
                  note_failure($sformatf({"mismatch: expected kind %0d byte %02h key %0d ",
                     "status %0d, got kind %0d byte %02h key %0d status %0d"},
                     oldest.kind, oldest.value_byte, oldest.key, oldest.status,
                     rsp_kind, rsp_value_byte, rsp_key, rsp_status));
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

[sim/key_value_line_parser_core_tb.sv]
// Testbench top for key_value_line_parser_core: drives directed and random load lines
// with random gaps on both queues and gives the verdict.
// Depends on klp_pkg, the parser RTL and klp_line_checker.

module key_value_line_parser_core_tb;
   import klp_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 400;
   localparam int LONG_HOLD    = 300;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [7:0]         req_char_byte;
   logic               req_is_end;
   logic               rsp_empty;
   logic               rsp_pop;
   logic               rsp_kind;
   logic [7:0]         rsp_value_byte;
   logic signed [31:0] rsp_key;
   logic               rsp_status;

   int error_count;
   int pending;
   int cycle_count;
   int sent_words;
   int hold_asked;
   int hold_seen;
   int line_count;

   logic [7:0] line_text[$];

   key_value_line_parser_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_byte  (req_char_byte),
      .req_is_end     (req_is_end),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_value_byte (rsp_value_byte),
      .rsp_key        (rsp_key),
      .rsp_status     (rsp_status)
   );

   klp_line_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_byte  (req_char_byte),
      .req_is_end     (req_is_end),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_value_byte (rsp_value_byte),
      .rsp_key        (rsp_key),
      .rsp_status     (rsp_status),
      .error_count    (error_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_char_byte = '0;
      req_is_end = 1'b0;
      rsp_pop = 1'b0;
      cycle_count = 0;
      sent_words = 0;
      hold_asked = 0;
      hold_seen = 0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("key_value_line_parser_core test failed");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Printable most of the time, occasionally any byte including zero.
   function automatic logic [7:0] text_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 8'($urandom_range(32, 126));
      if (roll < 95) return 8'($urandom_range(1, 255));
      return CH_NUL;
   endfunction

   task automatic send_word(input logic [7:0] c, input logic last);
      @(negedge clock);
      req_push      <= 1'b1;
      req_char_byte <= c;
      req_is_end    <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent_words++;
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic send_end();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic send_line(input bit steady);
      foreach (line_text[i]) begin
         if (!steady) pause_sender(pick_gap());
         send_word(line_text[i], 1'b0);
      end
      if (!steady) pause_sender(pick_gap());
      send_end();
   endtask

   // Mostly well-formed lines with random content; the rest is noise.
   task automatic build_line();
      logic [7:0] quote;
      int         digits;
      line_text.delete();
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(0, 10)) line_text.push_back(text_byte());
         return;
      end
      repeat ($urandom_range(0, 2))
         line_text.push_back($urandom_range(0, 1) ? CH_SPACE :
                             8'(CH_TAB + $urandom_range(0, 4)));
      if ($urandom_range(0, 99) < 30)
         line_text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      digits = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 12) : $urandom_range(0, 3);
      repeat (digits) line_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 99) < 10) line_text.push_back(text_byte());
      if ($urandom_range(0, 99) < 92) line_text.push_back(CH_COMMA);
      repeat ($urandom_range(0, 2))
         line_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      if ($urandom_range(0, 99) < 40) begin
         quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
         line_text.push_back(quote);
      end else begin
         quote = CH_NEWLINE;
      end
      repeat ($urandom_range(0, 8)) line_text.push_back(text_byte());
      if ($urandom_range(0, 1)) begin
         line_text.push_back(quote);
         repeat ($urandom_range(0, 3)) line_text.push_back(text_byte());
      end
   endtask

   // Receiver: random pop bursts and gaps, plus a long hold-off when asked.
   initial begin
      int burst_left;
      int idle_left;
      burst_left = 0;
      idle_left  = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (burst_left == 0 && idle_left == 0) begin
               burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
               idle_left  = pick_gap();
            end
            if (burst_left > 0) begin
               rsp_pop <= 1'b1;
               burst_left--;
            end else begin
               rsp_pop <= 1'b0;
               idle_left--;
            end
         end
      end
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed lines: minus sign with a quoted value and a byte after the quote,
      // a missing comma, a sign with no digits and nothing after the comma,
      // a newline right after the blanks, and a zero byte inside a quoted value.
      send_text("-7,'a'b");
      send_end();
      send_text("\t9");
      send_end();
      send_text("+,");
      send_end();
      send_text(", \n");
      send_end();
      send_text("8,\"");
      send_word(8'hFF, 1'b0);
      send_word(CH_NUL, 1'b0);
      send_text("z");
      send_end();
      wait_for_results();

      sent_words = 0;
      line_count = 0;
      while (sent_words < RANDOM_WORDS) begin
         if (line_count == 8) begin
            // Hold the result side off while a long value keeps coming.
            hold_asked++;
            line_text.delete();
            line_text.push_back(8'(CH_ZERO + 1));
            line_text.push_back(CH_COMMA);
            repeat (24) line_text.push_back(8'($urandom_range(97, 122)));
            send_line(1'b1);
         end else begin
            if (line_count == 40) wait_for_results();
            build_line();
            send_line($urandom_range(0, 3) == 0);
         end
         line_count++;
      end

      wait_for_results();
      repeat (10) @(negedge clock);
      if (error_count == 0 && pending == 0 && rsp_empty) begin
         $display("key_value_line_parser_core test passed");
      end else begin
         $display("key_value_line_parser_core test failed");
      end
      $finish;
   end

endmodule
